// ===== design/fsv_pkg.sv =====
// shared types, constants and tables of the formant speech voice
package fsv_pkg;

  localparam int FORMANT_COUNT = 3;
  localparam int FIDX_W = 2;
  localparam int ROW_COUNT = 17;
  localparam logic [FIDX_W-1:0] LAST_FORMANT = 2'd2;
  localparam logic [1:0] LAST_TAYLOR = 2'd2;

  localparam logic [4:0] VOWEL_ROWS = 5'd9;
  localparam logic [4:0] LAST_ROW = 5'd16;
  localparam logic [20:0] PITCH_LIMIT = 21'h100000;
  localparam logic [31:0] SAMPLE_RATE = 32'd48000;
  localparam logic [31:0] THETA_SCALE = 32'd1686629713;
  localparam logic [30:0] TERM_ONE = 31'h4000_0000;
  localparam logic [31:0] TAYLOR_FIRST = 32'd72;
  localparam logic [31:0] TAYLOR_DIV [3] = '{32'd42, 32'd20, 32'd6};

  localparam logic [6:0] BLOCK_LENGTH_RESET = 7'd12;
  localparam logic [11:0] CONSONANT_LENGTH_RESET = 12'd2400;

  typedef enum logic {
    REG_BLOCK_LENGTH     = 1'b0,
    REG_CONSONANT_LENGTH = 1'b1
  } reg_index_e;

  localparam logic [7:0] ROW_FREQ [ROW_COUNT][FORMANT_COUNT] = '{
    '{8'd60, 8'd90, 8'd200}, '{8'd40, 8'd114, 8'd139}, '{8'd33, 8'd155, 8'd209},
    '{8'd22, 8'd189, 8'd247}, '{8'd51, 8'd99, 8'd195}, '{8'd29, 8'd65, 8'd180},
    '{8'd13, 8'd103, 8'd182}, '{8'd20, 8'd114, 8'd213}, '{8'd13, 8'd164, 8'd222},
    '{8'd13, 8'd121, 8'd254}, '{8'd40, 8'd112, 8'd114}, '{8'd24, 8'd54, 8'd157},
    '{8'd33, 8'd155, 8'd166}, '{8'd36, 8'd83, 8'd249}, '{8'd40, 8'd114, 8'd139},
    '{8'd13, 8'd58, 8'd182}, '{8'd13, 8'd164, 8'd222}
  };

  localparam logic [3:0] ROW_AMP [ROW_COUNT][FORMANT_COUNT] = '{
    '{4'd15, 4'd13, 4'd1}, '{4'd13, 4'd12, 4'd6}, '{4'd14, 4'd12, 4'd7},
    '{4'd13, 4'd10, 4'd8}, '{4'd15, 4'd12, 4'd1}, '{4'd13, 4'd8, 4'd0},
    '{4'd12, 4'd3, 4'd0}, '{4'd15, 4'd3, 4'd0}, '{4'd7, 4'd3, 4'd14},
    '{4'd9, 4'd9, 4'd0}, '{4'd12, 4'd10, 4'd5}, '{4'd13, 4'd8, 4'd0},
    '{4'd14, 4'd12, 4'd7}, '{4'd14, 4'd8, 4'd1}, '{4'd14, 4'd12, 4'd6},
    '{4'd5, 4'd5, 4'd5}, '{4'd7, 4'd10, 4'd14}
  };

  localparam logic [15:0] LEVEL_TABLE [16] = '{
    16'd2048, 16'd2462, 16'd2959, 16'd3557, 16'd4275, 16'd5139, 16'd6177, 16'd7425,
    16'd8925, 16'd10728, 16'd12895, 16'd15500, 16'd18632, 16'd22396, 16'd26920,
    16'd32358
  };

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] n;
    logic [31:0] d;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] q;
  } div_rsp_t;

endpackage

// ===== design/fsv_mul.sv =====
// bit-serial 32x32 unsigned multiplier, one multiplier bit per cycle
module fsv_mul import fsv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] a_q;
  logic [31:0] hi_q;
  logic [31:0] lo_q;
  logic [32:0] sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : 33'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        a_q    <= req_i.a;
        hi_q   <= '0;
        lo_q   <= req_i.b;
      end else if (busy_q) begin
        hi_q  <= sum[32:1];
        lo_q  <= {sum[0], lo_q[31:1]};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.p    = {hi_q, lo_q};

endmodule

// ===== design/fsv_div.sv =====
// restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle
module fsv_div import fsv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] d_q;
  logic [31:0] rem_q;
  logic [63:0] quo_q;
  logic [32:0] part;
  logic [33:0] trial;
  logic        ge;

  assign part  = {rem_q, quo_q[63]};
  assign trial = {1'b0, part} - {2'b0, d_q};
  assign ge    = !trial[33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      d_q    <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        d_q    <= req_i.d;
        rem_q  <= '0;
        quo_q  <= req_i.n;
      end else if (busy_q) begin
        rem_q <= ge ? trial[31:0] : part[31:0];
        quo_q <= {quo_q[62:0], ge};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.q    = quo_q;

endmodule

// ===== design/fsv_regs.sv =====
// apb configuration registers of the formant speech voice
module fsv_regs import fsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [6:0]  block_length_o,
  output logic [11:0] consonant_length_o
);

  logic [6:0]  bl_q;
  logic [11:0] cl_q;
  reg_index_e  sel;

  assign sel    = reg_index_e'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_q <= BLOCK_LENGTH_RESET;
      cl_q <= CONSONANT_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (sel)
        REG_BLOCK_LENGTH:     bl_q <= pwdata[6:0];
        REG_CONSONANT_LENGTH: cl_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_BLOCK_LENGTH:     prdata = {25'd0, bl_q};
      REG_CONSONANT_LENGTH: prdata = {20'd0, cl_q};
      default:              prdata = '0;
    endcase
  end

  assign block_length_o     = bl_q;
  assign consonant_length_o = cl_q;

endmodule

// ===== design/formant_speech_voice_top.sv =====
// top level of the three-formant speech voice
// One input transaction is one audio sample tick and gives one output transaction with
// the pulse excitation and the formant voice sample, both signed Q2.16 and saturated.
// All multiplications and divisions run through one bit-serial multiplier and one
// restoring divider, stepped by a sequencer: a tick in which the pitch phase wraps also
// works out the sub-sample edge position, and a tick that starts a block also runs the
// formant table blend and the pitch ramp.
// The three sine values come from a Taylor series evaluated on the shared units, which
// is most of the work of a tick. A new transaction is taken as soon as the sequencer
// is back in idle, while the previous result may still wait in the output register.
// Configuration writes go through the apb port: block length at address 0, consonant
// length at address 4; write them only while the block is idle.
module formant_speech_voice_top import fsv_pkg::*; #(
  parameter int SINE_ENTRIES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        block_start_i,
  input  logic        consonant_trigger_i,
  input  logic [23:0] pitch_increment_i,
  input  logic [15:0] vowel_position_i,
  input  logic [15:0] formant_shift_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [17:0] excitation_sample_o,
  output logic [17:0] voice_sample_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CTRL, S_FA, S_FB, S_FC, S_FD, S_LA, S_LB, S_STEP,
    S_TICK, S_TDIV, S_TFP, S_TT, S_TU, S_LP,
    S_SN0, S_SN1, S_SN2, S_SN3, S_SN4, S_SN5, S_SN6, S_SN7, S_SN8,
    S_OM, S_OUT
  } state_e;

  // saturate a 30-bit signed value into 18 or 24 bits
  function automatic logic [17:0] sat18(input logic [29:0] v);
    if (v[29:17] == {13{v[29]}}) return v[17:0];
    return v[29] ? 18'h20000 : 18'h1FFFF;
  endfunction

  function automatic logic [23:0] sat24(input logic [29:0] v);
    if (v[29:23] == {7{v[29]}}) return v[23:0];
    return v[29] ? 24'h800000 : 24'h7FFFFF;
  endfunction

  // configuration
  logic [6:0]  block_length;
  logic [11:0] consonant_length;

  fsv_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .block_length_o     (block_length),
    .consonant_length_o (consonant_length)
  );

  // shared serial units
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  fsv_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp));
  fsv_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // sequencer and latched transaction
  state_e            state_q;
  logic              pend_q;
  logic [FIDX_W-1:0] idx_q;
  logic [1:0]        k_q;
  logic              start_q;
  logic              trig_q;
  logic [20:0]       pinc_q;
  logic [15:0]       vow_q;
  logic [15:0]       sh_q;

  // voice state
  logic [31:0] phase_q;
  logic [31:0] cp_q;
  logic [31:0] step_q;
  logic [6:0]  ticks_q;
  logic [23:0] carried_q;
  logic [23:0] lp_q;
  logic [31:0] fp_q   [FORMANT_COUNT];
  logic [31:0] finc_q [FORMANT_COUNT];
  logic [15:0] lvl_q  [FORMANT_COUNT];
  logic [11:0] cd_q;
  logic [2:0]  choice_q;

  // working registers
  logic [4:0]  row_q;
  logic [4:0]  row2_q;
  logic [15:0] frac_q;
  logic [16:0] omf_q;
  logic [17:0] factor_q;
  logic [63:0] acc_q;
  logic [31:0] freq_q;
  logic [15:0] t_q;
  logic [25:0] pthis_q;
  logic [31:0] pv_q;
  logic [31:0] th_q;
  logic [31:0] x2_q;
  logic [30:0] term_q;
  logic        neg_q;
  logic [16:0] r_q;
  logic [35:0] s_q;
  logic        out_valid_q;
  logic [17:0] exc_q;
  logic [17:0] voi_q;
  logic [17:0] exc_out_q;
  logic [17:0] voi_out_q;

  // block start control math
  logic [6:0]  len_c;
  logic [27:0] mix_c;
  logic [2:0]  choice_c;
  logic [11:0] cd_sel;
  logic [11:0] cd_after;
  logic [34:0] pos_c;
  logic [4:0]  row_c;
  logic [4:0]  row2_c;
  logic [15:0] frac_c;
  logic [18:0] five_sh;
  logic [17:0] factor_c;
  logic [33:0] diff_c;
  logic [33:0] diff_mag;

  always_comb begin
    len_c    = (block_length == 7'd0) ? 7'd1 : block_length;
    mix_c    = {4'd0, vow_q, 8'd0} + {7'd0, pinc_q} + {6'd0, pinc_q, 1'b0}
             + {1'b0, sh_q, 11'd0} - {4'd0, sh_q, 8'd0};
    choice_c = trig_q ? mix_c[23:21] : choice_q;
    cd_sel   = trig_q ? consonant_length : cd_q;
    cd_after = cd_sel - ((cd_sel < {5'd0, len_c}) ? cd_sel : {5'd0, len_c});
    pos_c    = {vow_q, 19'd0} - {16'd0, vow_q, 3'd0} + {19'd0, vow_q};
    if (cd_after != 12'd0) begin
      row_c  = {2'd0, choice_c} + VOWEL_ROWS;
      frac_c = '0;
    end else begin
      row_c  = {2'd0, pos_c[34:32]};
      frac_c = pos_c[31:16];
    end
    if (row_c > LAST_ROW) row_c = LAST_ROW;
    row2_c   = (row_c >= LAST_ROW) ? LAST_ROW : row_c + 5'd1;
    five_sh  = {1'b0, sh_q, 2'b00} + {3'd0, sh_q};
    factor_c = 18'h10000 + five_sh[18:1];
    diff_c   = {5'd0, pinc_q, 8'd0} - {2'd0, cp_q};
    diff_mag = diff_c[33] ? (~diff_c + 34'd1) : diff_c;
  end

  // per-tick math
  logic [31:0] freq_c;
  logic [32:0] sum_c;
  logic [26:0] d_c;
  logic        d_neg;
  logic [26:0] d_mag;
  logic [16:0] coef_c;
  logic [16:0] u_c;
  logic [31:0] qv_c;
  logic        qneg_c;
  logic        s_neg;
  logic [35:0] s_mag;
  logic [32:0] om_full;
  logic [16:0] om_c;

  always_comb begin
    freq_c  = (ticks_q != 7'd0) ? cp_q + step_q : cp_q;
    sum_c   = {1'b0, phase_q} + {1'b0, freq_c};
    d_c     = {pthis_q[25], pthis_q} - 27'h200000 - {{3{lp_q[23]}}, lp_q};
    d_neg   = d_c[26];
    d_mag   = d_neg ? (~d_c + 27'd1) : d_c;
    coef_c  = (freq_q[31:12] > 20'h10000) ? 17'h10000 : freq_q[28:12];
    u_c     = 17'h10000 - {1'b0, t_q};
    // fold the sine phase onto the first quarter wave
    if (pv_q < 32'h4000_0000) begin
      qv_c = pv_q;                 qneg_c = 1'b0;
    end else if (pv_q < 32'h8000_0000) begin
      qv_c = 32'h8000_0000 - pv_q; qneg_c = 1'b0;
    end else if (pv_q < 32'hC000_0000) begin
      qv_c = pv_q - 32'h8000_0000; qneg_c = 1'b1;
    end else begin
      qv_c = 32'd0 - pv_q;         qneg_c = 1'b1;
    end
    s_neg   = s_q[35];
    s_mag   = s_neg ? (~s_q + 36'd1) : s_q;
    om_full = {1'b1, 32'd0} - {1'b0, phase_q};
    om_c    = om_full[32:16];
  end

  // results taken from the units
  logic [63:0] mp;
  logic [63:0] dq;
  logic [32:0] lvl_sum;
  logic [45:0] lp_pm;
  logic [45:0] lp_ps;
  logic [29:0] lp_new;
  logic [50:0] om_pm;
  logic [50:0] om_ps;
  logic [32:0] r_sum;
  logic [22:0] blep_next;

  always_comb begin
    mp        = mul_rsp.p;
    dq        = div_rsp.q;
    lvl_sum   = acc_q[32:0] + mp[32:0];
    lp_pm     = {1'b0, mp[44:0]};
    lp_ps     = d_neg ? (~lp_pm + 46'd1) : lp_pm;
    lp_new    = {{6{lp_q[23]}}, lp_q} + lp_ps[45:16];
    om_pm     = {1'b0, mp[49:0]};
    om_ps     = s_neg ? (~om_pm + 51'd1) : om_pm;
    r_sum     = {1'b0, mp[61:30]} + 33'h4000;
    blep_next = {1'b0, mp[32:11]} + {1'b0, phase_q[31:10]};
  end

  // operand selection for the shared units
  logic mul_op;
  logic div_op;
  logic op_done;
  logic res_ok;

  always_comb begin
    mul_op  = 1'b0;
    div_op  = 1'b0;
    mul_req = '0;
    div_req = '0;
    case (state_q)
      S_FA: begin
        mul_op = 1'b1;
        mul_req.a = {24'd0, ROW_FREQ[row_q][idx_q]};
        mul_req.b = {15'd0, omf_q};
      end
      S_FB: begin
        mul_op = 1'b1;
        mul_req.a = {24'd0, ROW_FREQ[row2_q][idx_q]};
        mul_req.b = {16'd0, frac_q};
      end
      S_FC: begin
        mul_op = 1'b1;
        mul_req.a = acc_q[31:0];
        mul_req.b = {14'd0, factor_q};
      end
      S_FD: begin
        div_op = 1'b1;
        div_req.n = {acc_q[60:0], 3'd0};
        div_req.d = SAMPLE_RATE;
      end
      S_LA: begin
        mul_op = 1'b1;
        mul_req.a = {16'd0, LEVEL_TABLE[ROW_AMP[row_q][idx_q]]};
        mul_req.b = {15'd0, omf_q};
      end
      S_LB: begin
        mul_op = 1'b1;
        mul_req.a = {16'd0, LEVEL_TABLE[ROW_AMP[row2_q][idx_q]]};
        mul_req.b = {16'd0, frac_q};
      end
      S_STEP: begin
        div_op = 1'b1;
        div_req.n = {30'd0, diff_mag};
        div_req.d = {25'd0, len_c};
      end
      S_TDIV: begin
        div_op = 1'b1;
        div_req.n = {16'd0, phase_q, 16'd0};
        div_req.d = freq_q;
      end
      S_TFP: begin
        mul_op = 1'b1;
        mul_req.a = {16'd0, t_q};
        mul_req.b = finc_q[idx_q];
      end
      S_TT: begin
        mul_op = 1'b1;
        mul_req.a = {16'd0, t_q};
        mul_req.b = {16'd0, t_q};
      end
      S_TU: begin
        mul_op = 1'b1;
        mul_req.a = {15'd0, u_c};
        mul_req.b = {15'd0, u_c};
      end
      S_LP: begin
        mul_op = 1'b1;
        mul_req.a = {15'd0, coef_c};
        mul_req.b = {5'd0, d_mag};
      end
      S_SN0: begin
        mul_op = 1'b1;
        mul_req.a = fp_q[idx_q];
        mul_req.b = 32'(SINE_ENTRIES);
      end
      S_SN1: begin
        div_op = 1'b1;
        div_req.n = {acc_q[31:0], 32'd0};
        div_req.d = 32'(SINE_ENTRIES);
      end
      S_SN2: begin
        mul_op = 1'b1;
        mul_req.a = qv_c;
        mul_req.b = THETA_SCALE;
      end
      S_SN3: begin
        mul_op = 1'b1;
        mul_req.a = th_q;
        mul_req.b = th_q;
      end
      S_SN4: begin
        div_op = 1'b1;
        div_req.n = {32'd0, x2_q};
        div_req.d = TAYLOR_FIRST;
      end
      S_SN5: begin
        mul_op = 1'b1;
        mul_req.a = x2_q;
        mul_req.b = {1'b0, term_q};
      end
      S_SN6: begin
        div_op = 1'b1;
        div_req.n = acc_q;
        div_req.d = TAYLOR_DIV[k_q];
      end
      S_SN7: begin
        mul_op = 1'b1;
        mul_req.a = th_q;
        mul_req.b = {1'b0, term_q};
      end
      S_SN8: begin
        mul_op = 1'b1;
        mul_req.a = {15'd0, r_q};
        mul_req.b = {16'd0, lvl_q[idx_q]};
      end
      S_OM: begin
        mul_op = 1'b1;
        mul_req.a = s_mag[31:0];
        mul_req.b = {15'd0, om_c};
      end
      default: ;
    endcase
    mul_req.start = mul_op && !pend_q;
    div_req.start = div_op && !pend_q;
    op_done = mul_op ? mul_rsp.done : div_rsp.done;
    res_ok  = pend_q && op_done;
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
      start_q     <= 1'b0;
      trig_q      <= 1'b0;
      pinc_q      <= '0;
      vow_q       <= '0;
      sh_q        <= '0;
      phase_q     <= '0;
      cp_q        <= '0;
      step_q      <= '0;
      ticks_q     <= '0;
      carried_q   <= '0;
      lp_q        <= '0;
      for (int i = 0; i < FORMANT_COUNT; i++) begin
        fp_q[i]   <= '0;
        finc_q[i] <= '0;
        lvl_q[i]  <= '0;
      end
      cd_q        <= '0;
      choice_q    <= '0;
      row_q       <= '0;
      row2_q      <= '0;
      frac_q      <= '0;
      omf_q       <= '0;
      factor_q    <= '0;
      acc_q       <= '0;
      freq_q      <= '0;
      t_q         <= '0;
      pthis_q     <= '0;
      pv_q        <= '0;
      th_q        <= '0;
      x2_q        <= '0;
      term_q      <= '0;
      neg_q       <= 1'b0;
      r_q         <= '0;
      s_q         <= '0;
      exc_q       <= '0;
      voi_q       <= '0;
      out_valid_q <= 1'b0;
      exc_out_q   <= '0;
      voi_out_q   <= '0;
    end else begin
      if (mul_op || div_op) begin
        if (!pend_q) pend_q <= 1'b1;
        else if (op_done) pend_q <= 1'b0;
      end
      if (out_valid_q && out_ready_i && state_q != S_OUT) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            start_q <= block_start_i;
            trig_q  <= consonant_trigger_i;
            pinc_q  <= (pitch_increment_i > {3'd0, PITCH_LIMIT}) ? PITCH_LIMIT
                                                                : pitch_increment_i[20:0];
            vow_q   <= vowel_position_i;
            sh_q    <= formant_shift_i;
            state_q <= block_start_i ? S_CTRL : S_TICK;
          end
        end
        // latch the block controls
        S_CTRL: begin
          cd_q     <= cd_after;
          choice_q <= choice_c;
          row_q    <= row_c;
          row2_q   <= row2_c;
          frac_q   <= frac_c;
          omf_q    <= 17'h10000 - {1'b0, frac_c};
          factor_q <= factor_c;
          idx_q    <= '0;
          state_q  <= S_FA;
        end
        S_FA: if (res_ok) begin
          acc_q   <= mp;
          state_q <= S_FB;
        end
        S_FB: if (res_ok) begin
          acc_q   <= acc_q + mp;
          state_q <= S_FC;
        end
        S_FC: if (res_ok) begin
          acc_q   <= mp;
          state_q <= S_FD;
        end
        S_FD: if (res_ok) begin
          finc_q[idx_q] <= dq[31:0];
          state_q       <= S_LA;
        end
        S_LA: if (res_ok) begin
          acc_q   <= mp;
          state_q <= S_LB;
        end
        S_LB: if (res_ok) begin
          lvl_q[idx_q] <= lvl_sum[31:16];
          if (idx_q == LAST_FORMANT) begin
            state_q <= S_STEP;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_FA;
          end
        end
        // pitch ramp step, truncated toward zero
        S_STEP: if (res_ok) begin
          step_q  <= diff_c[33] ? (32'd0 - dq[31:0]) : dq[31:0];
          ticks_q <= len_c;
          state_q <= S_TICK;
        end
        S_TICK: begin
          cp_q    <= freq_c;
          freq_q  <= freq_c;
          if (ticks_q != 7'd0) ticks_q <= ticks_q - 7'd1;
          phase_q <= sum_c[31:0];
          pthis_q <= {2'd0, carried_q};
          if (sum_c[32]) begin
            state_q <= S_TDIV;
          end else begin
            for (int i = 0; i < FORMANT_COUNT; i++) fp_q[i] <= fp_q[i] + finc_q[i];
            carried_q <= {2'd0, sum_c[31:10]};
            state_q   <= S_LP;
          end
        end
        // wrap: fractional position of the edge inside this tick
        S_TDIV: if (res_ok) begin
          t_q     <= (dq > 64'd65535) ? 16'hFFFF : dq[15:0];
          idx_q   <= '0;
          state_q <= S_TFP;
        end
        S_TFP: if (res_ok) begin
          fp_q[idx_q] <= mp[47:16];
          if (idx_q == LAST_FORMANT) begin
            state_q <= S_TT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_TT: if (res_ok) begin
          pthis_q <= pthis_q - {4'd0, mp[32:11]};
          state_q <= S_TU;
        end
        S_TU: if (res_ok) begin
          carried_q <= {1'b0, blep_next};
          state_q   <= S_LP;
        end
        // leaky lowpass on the pulse and the excitation output
        S_LP: if (res_ok) begin
          lp_q    <= sat24(lp_new);
          exc_q   <= sat18({{9{d_c[26]}}, d_c[26:6]});
          idx_q   <= '0;
          s_q     <= '0;
          state_q <= S_SN0;
        end
        S_SN0: if (res_ok) begin
          acc_q   <= {32'd0, mp[63:32]};
          state_q <= S_SN1;
        end
        S_SN1: if (res_ok) begin
          pv_q    <= dq[31:0];
          state_q <= S_SN2;
        end
        S_SN2: if (res_ok) begin
          th_q    <= mp[61:30];
          neg_q   <= qneg_c;
          state_q <= S_SN3;
        end
        S_SN3: if (res_ok) begin
          x2_q    <= mp[61:30];
          state_q <= S_SN4;
        end
        S_SN4: if (res_ok) begin
          term_q  <= TERM_ONE - dq[30:0];
          k_q     <= '0;
          state_q <= S_SN5;
        end
        S_SN5: if (res_ok) begin
          acc_q   <= {31'd0, mp[62:30]};
          state_q <= S_SN6;
        end
        S_SN6: if (res_ok) begin
          term_q <= TERM_ONE - dq[30:0];
          if (k_q == LAST_TAYLOR) begin
            state_q <= S_SN7;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_SN5;
          end
        end
        S_SN7: if (res_ok) begin
          r_q     <= r_sum[31:15];
          state_q <= S_SN8;
        end
        S_SN8: if (res_ok) begin
          s_q <= neg_q ? s_q - {4'd0, mp[31:0]} : s_q + {4'd0, mp[31:0]};
          if (idx_q == LAST_FORMANT) begin
            state_q <= S_OM;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SN0;
          end
        end
        // scale the formant sum by one minus the pitch phase
        S_OM: if (res_ok) begin
          voi_q   <= sat18({{10{om_ps[50]}}, om_ps[50:31]});
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            exc_out_q   <= exc_q;
            voi_out_q   <= voi_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign excitation_sample_o = exc_out_q;
  assign voice_sample_o      = voi_out_q;

  // the sequencer never restarts a unit that is still working
  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier restarted while busy");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // the multiplier never starts while the divider is still working
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !div_rsp.busy)
    else $error("multiplier started while divider busy");

  // an accepted transaction always leaves idle
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("transaction accepted but sequencer stayed idle");

endmodule

// ===== verif/tb.sv =====
// self-checking testbench of the three-formant speech voice top level
module tb;
  import fsv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // sine table size of the instance, and the sample rate used by the predictor
  localparam int unsigned SINE_N = 1024;
  localparam longint unsigned RATE = 48000;
  localparam longint unsigned WRAP32 = 64'h1_0000_0000;
  // bound on the whole run, with room for the worst tick, receiver stalls and sender gaps
  localparam longint CYCLE_LIMIT = 64'd30_000_000;
  localparam int RANDOM_PER_PHASE = 350;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        block_start_i;
  logic        consonant_trigger_i;
  logic [23:0] pitch_increment_i;
  logic [15:0] vowel_position_i;
  logic [15:0] formant_shift_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [17:0] excitation_sample_o;
  logic [17:0] voice_sample_o;

  formant_speech_voice_top #(.SINE_ENTRIES(SINE_N)) dut (.*);

  // one expected output transaction
  typedef struct packed {
    logic [17:0] excitation;
    logic [17:0] voice;
  } voice_out_t;

  voice_out_t sample_queue[$];
  int         error_count;
  longint     cycle_count;

  // predictor copy of the registers and the voice state
  logic [6:0]  cfg_block_len;
  logic [11:0] cfg_cons_len;
  logic [31:0] phase_acc;
  logic [31:0] pitch_now;
  logic [31:0] ramp_step;
  logic [6:0]  ticks_left;
  logic [23:0] blep_carry;
  longint      lowpass_acc;
  logic [31:0] fmt_phase [FORMANT_COUNT];
  logic [31:0] fmt_inc   [FORMANT_COUNT];
  logic [15:0] fmt_level [FORMANT_COUNT];
  logic [11:0] cons_count;
  logic [2:0]  cons_pick;

  // sender burst bookkeeping
  int burst_left;

  // clock, 4 ns period
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [17:0] want,
                                 input logic [17:0] got);
    error_count++;
    $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // quarter-wave taylor sine in q15 at the table slot of the phase
  function automatic longint sine_slot_q15(input logic [31:0] ph);
    longint unsigned slot, p, q, th, x2, term, r;
    bit neg;
    slot = (longint'(ph) * SINE_N) >> 32;
    p = (slot << 32) / SINE_N;
    neg = 1'b0;
    if (p < (64'd1 << 30)) q = p;
    else if (p < (64'd1 << 31)) q = (64'd1 << 31) - p;
    else if (p < (64'd3 << 30)) begin
      q = p - (64'd1 << 31);
      neg = 1'b1;
    end else begin
      q = WRAP32 - p;
      neg = 1'b1;
    end
    th = (q * 64'd1686629713) >> 30;
    x2 = (th * th) >> 30;
    term = (64'd1 << 30) - x2 / 72;
    term = (64'd1 << 30) - ((x2 * term) >> 30) / 42;
    term = (64'd1 << 30) - ((x2 * term) >> 30) / 20;
    term = (64'd1 << 30) - ((x2 * term) >> 30) / 6;
    r = (((th * term) >> 30) + (64'd1 << 14)) >> 15;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // advances the voice state by one tick and returns the expected samples
  function automatic voice_out_t voice_tick(input bit start, input bit trig,
                                            input logic [23:0] pitch_in,
                                            input logic [15:0] vow, input logic [15:0] sh);
    voice_out_t res;
    longint unsigned pinc, len, row, row2, frac, factor, f, a, pos, mix, sum, t, u, coef;
    longint unsigned one_minus;
    longint diff, pthis, pnext, d, lp, s;
    pinc = pitch_in > 24'h100000 ? 64'h100000 : longint'(pitch_in);
    if (start) begin
      len = cfg_block_len != 0 ? cfg_block_len : 1;
      if (trig) begin
        mix = (longint'(vow) << 8) + 3 * pinc + 7 * (longint'(sh) << 8);
        cons_count = cfg_cons_len;
        cons_pick = mix[23:21];
      end
      cons_count = cons_count - (cons_count < len ? cons_count : len[11:0]);
      if (cons_count != 0) begin
        row = cons_pick + 9;
        frac = 0;
      end else begin
        pos = (longint'(vow) * 524281) >> 16;
        row = pos >> 16;
        frac = pos & 64'hFFFF;
      end
      if (row > 16) row = 16;
      row2 = row + 1 > 16 ? 16 : row + 1;
      factor = 65536 + ((5 * longint'(sh)) >> 1);
      for (int i = 0; i < FORMANT_COUNT; i++) begin
        f = ROW_FREQ[row][i] * (65536 - frac) + ROW_FREQ[row2][i] * frac;
        a = LEVEL_TABLE[ROW_AMP[row][i]] * (65536 - frac)
          + LEVEL_TABLE[ROW_AMP[row2][i]] * frac;
        fmt_inc[i] = (f * factor * 8) / RATE;
        fmt_level[i] = a >> 16;
      end
      diff = longint'(pinc << 8) - longint'({32'd0, pitch_now});
      ramp_step = diff / longint'(len);
      ticks_left = len;
    end

    if (ticks_left != 0) begin
      pitch_now = pitch_now + ramp_step;
      ticks_left = ticks_left - 1;
    end

    pthis = longint'({40'd0, blep_carry});
    pnext = 0;
    sum = longint'({32'd0, phase_acc}) + longint'({32'd0, pitch_now});
    if (sum >= WRAP32) begin
      phase_acc = sum - WRAP32;
      t = pitch_now != 0 ? ((longint'({32'd0, phase_acc}) << 16) / pitch_now) : 0;
      if (t > 65535) t = 65535;
      // formant phases restart at the sub-sample wrap point
      for (int i = 0; i < FORMANT_COUNT; i++)
        fmt_phase[i] = (t * fmt_inc[i]) >> 16;
      pthis = pthis - longint'((t * t) >> 11);
      u = 65536 - t;
      pnext = pnext + longint'((u * u) >> 11);
    end else begin
      phase_acc = sum[31:0];
      for (int i = 0; i < FORMANT_COUNT; i++)
        fmt_phase[i] = fmt_phase[i] + fmt_inc[i];
    end
    pnext = pnext + longint'({32'd0, phase_acc} >> 10);
    blep_carry = pnext[23:0];

    d = pthis - (64'sd1 <<< 21) - lowpass_acc;
    coef = pitch_now >> 12;
    if (coef > 65536) coef = 65536;
    lp = lowpass_acc + ((longint'(coef) * d) >>> 16);
    lowpass_acc = sat(lp, -8388608, 8388607);

    s = 0;
    for (int i = 0; i < FORMANT_COUNT; i++)
      s = s + sine_slot_q15(fmt_phase[i]) * longint'({48'd0, fmt_level[i]});
    one_minus = (WRAP32 - phase_acc) >> 16;
    s = (s * longint'(one_minus)) >>> 31;

    res.excitation = sat(d >>> 6, -131072, 131071);
    res.voice = sat(s, -131072, 131071);
    return res;
  endfunction

  // checker: every output transaction against the oldest expectation
  always @(posedge clk_i) begin
    voice_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sample_queue.size() == 0) begin
        error_count++;
        $display("output transaction with nothing expected");
      end else begin
        want = sample_queue.pop_front();
        if (excitation_sample_o !== want.excitation)
          report_mismatch("excitation", want.excitation, excitation_sample_o);
        if (voice_sample_o !== want.voice)
          report_mismatch("voice", want.voice, voice_sample_o);
      end
    end
  end

  // receiver: alternates between always ready, random stalls and long stalls
  initial begin
    int mode_left;
    int mode;
    mode_left = 0;
    mode = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode = $urandom_range(2);
        mode_left = $urandom_range(4000, 200);
      end
      mode_left--;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(1);
        default: begin
          // mostly low: ready is drawn high with a chance of one in 256
          out_ready_i <= ($urandom_range(255) == 0);
        end
      endcase
    end
  end

  // one apb write: setup cycle then access cycle
  task automatic apb_write(input reg_index_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_BLOCK_LENGTH) cfg_block_len = value[6:0];
    else cfg_cons_len = value[11:0];
  endtask

  // waits for all expected samples, then a short settle before touching registers
  task automatic drain_outputs();
    while (sample_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // sends one sample tick transaction; bursts with random gaps between them
  task automatic send_tick(input bit start, input bit trig, input logic [23:0] pitch,
                           input logic [15:0] vow, input logic [15:0] sh);
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      repeat ($urandom_range(40)) @(negedge clk_i);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    block_start_i <= start;
    consonant_trigger_i <= trig;
    pitch_increment_i <= pitch;
    vowel_position_i <= vow;
    formant_shift_i <= sh;
    do @(posedge clk_i); while (!in_ready_o);
    sample_queue.push_back(voice_tick(start, trig, pitch, vow, sh));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // directed ticks: idle voice, field extremes, last consonant row, pitch above range
  task automatic test_directed();
    send_tick(1'b0, 1'b0, 24'h0, 16'h0, 16'h0);
    send_tick(1'b0, 1'b1, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(1'b1, 1'b0, 24'h100000, 16'h0, 16'h0);
    for (int i = 0; i < 6; i++) send_tick(1'b0, 1'b0, 24'h0, 16'h0, 16'h0);
    send_tick(1'b1, 1'b0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_tick(1'b0, 1'b0, 24'h0, 16'h0, 16'h0);
    // consonant trigger with the mix that picks the last consonant row
    send_tick(1'b1, 1'b1, 24'h0, 16'hFFFF, 16'h0);
    send_tick(1'b0, 1'b0, 24'h0, 16'h0, 16'h0);
    send_tick(1'b1, 1'b1, 24'h0FFFFF, 16'h8000, 16'h8000);
    send_tick(1'b1, 1'b0, 24'h100001, 16'h1234, 16'h0001);
    send_tick(1'b1, 1'b0, 24'h000001, 16'h0001, 16'hFFFF);
    // ticks past the end of the block hold the pitch
    for (int i = 0; i < 14; i++) send_tick(1'b0, 1'b0, 24'h0, 16'h0, 16'h0);
  endtask

  function automatic logic [23:0] pick_pitch();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 24'h100000;
      2: return $urandom_range(24'hFFFFFF, 24'h100001);
      3: return $urandom_range(24'h00FFFF);
      default: return $urandom_range(24'h0FFFFF);
    endcase
  endfunction

  function automatic logic [15:0] pick_q16();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return $urandom();
    endcase
  endfunction

  // random ticks: mostly block starts on schedule, sometimes early or late
  task automatic test_random(input int count);
    int pos_in_block;
    int target;
    bit start;
    pos_in_block = 0;
    target = cfg_block_len == 0 ? 1 : cfg_block_len;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(19) == 0) start = $urandom_range(1);
      else start = (pos_in_block >= target);
      if (start) begin
        pos_in_block = 0;
        target = $urandom_range(3) == 0 ? $urandom_range(80, 1)
                                        : (cfg_block_len == 0 ? 1 : cfg_block_len);
      end
      pos_in_block++;
      send_tick(start, $urandom_range(7) == 0, pick_pitch(), pick_q16(), pick_q16());
    end
  endtask

  // one register setting followed by random ticks
  task automatic test_setting(input logic [6:0] blen, input logic [11:0] clen);
    drain_outputs();
    apb_write(REG_BLOCK_LENGTH, {25'd0, blen});
    apb_write(REG_CONSONANT_LENGTH, {20'd0, clen});
    test_random(RANDOM_PER_PHASE);
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    block_start_i = 1'b0;
    consonant_trigger_i = 1'b0;
    pitch_increment_i = '0;
    vowel_position_i = '0;
    formant_shift_i = '0;
    // predictor reset state
    cfg_block_len = BLOCK_LENGTH_RESET;
    cfg_cons_len = CONSONANT_LENGTH_RESET;
    phase_acc = '0;
    pitch_now = '0;
    ramp_step = '0;
    ticks_left = '0;
    blep_carry = '0;
    lowpass_acc = 0;
    for (int i = 0; i < FORMANT_COUNT; i++) begin
      fmt_phase[i] = '0;
      fmt_inc[i] = '0;
      fmt_level[i] = '0;
    end
    cons_count = '0;
    cons_pick = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    // zero block length acts as one
    test_setting(7'd0, 12'd1);
    test_setting(7'd64, 12'd4095);
    test_setting(7'd1, 12'd40);
    test_setting(7'd127, 12'd300);
    test_setting(7'($urandom_range(64, 2)), 12'($urandom_range(4095, 1)));

    drain_outputs();
    repeat (3000) @(posedge clk_i);
    if (error_count == 0 && sample_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
